>>> sv/lpcf_pkg.sv
// ============================================================================
// lpcf_pkg: shared types for the local peak clamp filter
// Transfer payloads and register indexes of the raster peak clamp core.
// ============================================================================
`default_nettype none

package lpcf_pkg;

    // Field widths of the stream payloads
    localparam int unsigned PIXEL_FIELD_W = 16;
    localparam int unsigned CFG_DATA_W    = 16;
    localparam int unsigned CFG_INDEX_W   = 1;

    // Input action codes
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    // Reset values of the configuration registers
    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [15:0] FRAME_HEIGHT_RST = 16'd1;

    typedef struct packed {
        logic                     action;
        logic [PIXEL_FIELD_W-1:0] pixel_in;
    } t_pixel_in;

    typedef struct packed {
        logic [PIXEL_FIELD_W-1:0] pixel_out;
        logic                     was_clipped;
        logic                     row_end;
        logic                     frame_end;
    } t_pixel_out;

endpackage

`default_nettype wire

>>> sv/local_peak_clamp_filter_core.sv
// Pipeline: a result passes the stage 2 register, then the output register,
//   after the transfer that emits it; results lag the pixel stream by one row.
// Throughput: one item per cycle while the output is not stalled, set by the two-port reads of the line store.
// Reset: clears positions, pending-row flag and pipeline valids, and loads the
//   register defaults; line store contents stay undefined, no clearing pass.
// ============================================================================
// local_peak_clamp_filter_core: raster 4-neighbor local peak clamp
// Two line stores (one per row parity) hold the current and previous rows.
// Stage 1 reads the window and writes the incoming pixel, stage 2 clamps,
// and an output register decouples the result from the input side.
// ============================================================================
`default_nettype none

module local_peak_clamp_filter_core #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned PIXEL_BITS = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // input stream
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  lpcf_pkg::t_pixel_in                  i_in_data,
    // output stream
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output lpcf_pkg::t_pixel_out                 o_out_data,
    // configuration write port
    input  wire                                  i_cfg_wr_en,
    input  wire  [lpcf_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire  [lpcf_pkg::CFG_DATA_W-1:0]      i_cfg_wr_data
);

    import lpcf_pkg::*;

    localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned CNT_W = COL_W + 1;
    localparam int unsigned PW    = (PIXEL_BITS < PIXEL_FIELD_W) ? PIXEL_BITS
                                                                 : PIXEL_FIELD_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [10:0] r_frame_width;
    logic [15:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wr_data[10:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Effective frame size
    logic [31:0]      w_full;
    logic [CNT_W-1:0] eff_w;
    logic [15:0]      eff_h;
    logic [15:0]      h_m1;

    always_comb begin
        if (r_frame_width == 11'd0) begin
            w_full = 32'd1;
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_full = 32'(MAX_WIDTH);
        end else begin
            w_full = 32'(r_frame_width);
        end
        eff_w = CNT_W'(w_full);
        eff_h = (r_frame_height == 16'd0) ? 16'd1 : r_frame_height;
        h_m1  = eff_h - 16'd1;
    end

    // ------------------------------------------------------------------
    // Pipeline handshake
    // ------------------------------------------------------------------
    logic r_s2_valid;
    logic r_out_valid;
    logic out_ready;
    logic s2_ready;
    logic s2_move;
    logic in_xfer;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s2_move    = r_s2_valid && out_ready;
    assign s2_ready   = !r_s2_valid || out_ready;
    assign o_in_stall = !s2_ready;
    assign in_xfer    = i_in_valid && s2_ready;

    // ------------------------------------------------------------------
    // Stage 1: position tracking and emit decision
    // ------------------------------------------------------------------
    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic [15:0]      r_in_row,  n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [15:0]      r_out_row, n_out_row;
    logic             r_row_ready, n_row_ready;

    logic             is_pixel;
    logic [PW-1:0]    pix;
    logic             last_row;
    logic             emit;
    logic [CNT_W-1:0] out_col_p1;
    logic [CNT_W-1:0] in_col_p1;
    logic             row_end;
    logic [16:0]      in_row_p1;

    always_comb begin
        is_pixel   = (i_in_data.action == ACT_PIXEL);
        pix        = i_in_data.pixel_in[PW-1:0];
        last_row   = (r_out_row >= h_m1);
        emit       = r_row_ready && (is_pixel || last_row);
        out_col_p1 = CNT_W'(r_out_col) + CNT_W'(1);
        in_col_p1  = CNT_W'(r_in_col) + CNT_W'(1);
        row_end    = (out_col_p1 >= eff_w);
        in_row_p1  = {1'b0, r_in_row} + 17'd1;

        n_in_col    = r_in_col;
        n_in_row    = r_in_row;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_row_ready = r_row_ready;

        // advance the output position
        if (emit) begin
            if (row_end) begin
                n_out_col   = '0;
                n_row_ready = 1'b0;
            end else begin
                n_out_col = COL_W'(out_col_p1);
            end
        end

        // advance the input position; a full row becomes pending
        if (is_pixel) begin
            if (in_col_p1 >= eff_w) begin
                n_in_col    = '0;
                n_row_ready = 1'b1;
                n_out_row   = r_in_row;
                n_out_col   = '0;
                n_in_row    = (in_row_p1 >= {1'b0, eff_h}) ? 16'd0 : in_row_p1[15:0];
            end else begin
                n_in_col = COL_W'(in_col_p1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_row_ready <= 1'b0;
        end else if (in_xfer) begin
            r_in_col    <= n_in_col;
            r_in_row    <= n_in_row;
            r_out_col   <= n_out_col;
            r_out_row   <= n_out_row;
            r_row_ready <= n_row_ready;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: one per row parity, read at the centre column and its
    // right neighbor, written with the incoming pixel (read-first)
    // ------------------------------------------------------------------
    logic [PW-1:0] mem_even [MAX_WIDTH];
    logic [PW-1:0] mem_odd  [MAX_WIDTH];

    logic [COL_W-1:0] rd_col_c;
    logic [COL_W-1:0] rd_col_r;
    logic             wr_en;

    assign rd_col_c = r_out_col;
    assign rd_col_r = COL_W'(out_col_p1);
    assign wr_en    = in_xfer && is_pixel;

    logic [PW-1:0] r_even_c;
    logic [PW-1:0] r_even_r;
    logic [PW-1:0] r_odd_c;
    logic [PW-1:0] r_odd_r;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_even_c <= mem_even[rd_col_c];
            r_even_r <= mem_even[rd_col_r];
        end
        if (wr_en && !r_in_row[0]) begin
            mem_even[r_in_col] <= pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_odd_c <= mem_odd[rd_col_c];
            r_odd_r <= mem_odd[rd_col_r];
        end
        if (wr_en && r_in_row[0]) begin
            mem_odd[r_in_col] <= pix;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 side information, captured with the line store reads
    // ------------------------------------------------------------------
    logic          r_s2_slot;
    logic          r_s2_has_up;
    logic          r_s2_has_down;
    logic          r_s2_has_left;
    logic          r_s2_has_right;
    logic          r_s2_row_end;
    logic          r_s2_frame_end;
    logic [PW-1:0] r_s2_down;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s2_valid <= emit;
        end else if (s2_move) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s2_slot      <= r_out_row[0];
            r_s2_has_up    <= (r_out_row != 16'd0);
            r_s2_has_down  <= !last_row;
            r_s2_has_left  <= (r_out_col != '0);
            r_s2_has_right <= !row_end;
            r_s2_row_end   <= row_end;
            r_s2_frame_end <= row_end && last_row;
            r_s2_down      <= pix;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: clamp a strict peak to its largest in-frame neighbor
    // ------------------------------------------------------------------
    logic [PW-1:0] r_left;
    logic [PW-1:0] centre;
    logic [PW-1:0] right_px;
    logic [PW-1:0] up_px;
    logic [PW-1:0] v_up;
    logic [PW-1:0] v_down;
    logic [PW-1:0] v_left;
    logic [PW-1:0] v_right;
    logic [PW-1:0] max_a;
    logic [PW-1:0] max_b;
    logic [PW-1:0] max_all;
    logic          any_nb;
    logic          peak;
    t_pixel_out    s2_result;

    always_comb begin
        centre   = r_s2_slot ? r_odd_c  : r_even_c;
        right_px = r_s2_slot ? r_odd_r  : r_even_r;
        up_px    = r_s2_slot ? r_even_c : r_odd_c;

        // absent neighbors count as zero, which never wins a max
        v_up    = r_s2_has_up    ? up_px     : '0;
        v_down  = r_s2_has_down  ? r_s2_down : '0;
        v_left  = r_s2_has_left  ? r_left    : '0;
        v_right = r_s2_has_right ? right_px  : '0;

        max_a   = (v_up > v_down)    ? v_up   : v_down;
        max_b   = (v_left > v_right) ? v_left : v_right;
        max_all = (max_a > max_b)    ? max_a  : max_b;

        any_nb  = r_s2_has_up || r_s2_has_down || r_s2_has_left || r_s2_has_right;
        peak    = any_nb && (centre > max_all);

        s2_result.pixel_out   = PIXEL_FIELD_W'(peak ? max_all : centre);
        s2_result.was_clipped = peak;
        s2_result.row_end     = r_s2_row_end;
        s2_result.frame_end   = r_s2_frame_end;
    end

    // Hold the previous centre as the next left neighbor
    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_left <= centre;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    t_pixel_out r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_out_data <= s2_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

>>> tb/sv/peak_clamp_checker.sv
// ============================================================================
// peak_clamp_checker: result checker for the local peak clamp filter
// Watches the pixel, result and register ports of the core. It keeps its own
// copy of the line stores and positions, works out the clamped pixel for
// every input transfer that emits one, and compares each result transfer
// against the oldest predicted pixel. Failures are counted and handed to the testbench top.
// ============================================================================

module peak_clamp_checker #(
    parameter int unsigned LINE_W       = 1024,
    parameter int unsigned REPORT_LIMIT = 10
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    input  wire                                  i_in_stall,
    input  lpcf_pkg::t_pixel_in                  i_in_data,
    input  wire                                  i_out_valid,
    input  wire                                  i_out_stall,
    input  lpcf_pkg::t_pixel_out                 i_out_data,
    input  wire                                  i_cfg_wr_en,
    input  wire  [lpcf_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire  [lpcf_pkg::CFG_DATA_W-1:0]      i_cfg_wr_data,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lpcf_pkg::*;

    // Shadow of the core: line stores, registers and raster positions
    logic [15:0]  line_mem [2*LINE_W];
    logic [10:0]  width_reg;
    logic [15:0]  height_reg;
    int unsigned  in_col;
    int unsigned  in_row;
    int unsigned  out_col;
    int unsigned  out_row;
    bit           row_pending;
    logic [15:0]  left_val;

    // Clamped pixels waiting for their result transfer
    t_pixel_out   clamped_pixel_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int unsigned width_in_use();
        if (width_reg == 0)
            return 1;
        if (width_reg > LINE_W)
            return LINE_W;
        return width_reg;
    endfunction

    function automatic int unsigned height_in_use();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    task automatic clear_shadow();
        for (int unsigned k = 0; k < 2 * LINE_W; k++)
            line_mem[k] = '0;
        width_reg   = FRAME_WIDTH_RST;
        height_reg  = FRAME_HEIGHT_RST;
        in_col      = 0;
        in_row      = 0;
        out_col     = 0;
        out_row     = 0;
        row_pending = 1'b0;
        left_val    = '0;
        clamped_pixel_q.delete();
    endtask

    // Emit the next pixel of the pending row (if this transfer allows it),
    // then store the incoming pixel and advance the input position.
    task automatic predict_clamped_pixel(input t_pixel_in item);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned base_cur;
        int unsigned base_up;
        logic [15:0] centre;
        logic [15:0] nb_max;
        bit          is_pixel;
        bit          last_row;
        bit          has_nb;
        bit          clip;
        bit          ends_row;
        t_pixel_out  res;

        w        = width_in_use();
        h        = height_in_use();
        is_pixel = (item.action == ACT_PIXEL);

        if (row_pending) begin
            last_row = (out_row >= h - 1);
            // a flush can only emit from the last row: no row below is coming
            if (is_pixel || last_row) begin
                col      = out_col;
                base_cur = (out_row & 1) * LINE_W;
                base_up  = ((out_row & 1) ^ 1) * LINE_W;
                centre   = line_mem[base_cur + col];
                nb_max   = '0;
                has_nb   = 1'b0;
                if (out_row > 0) begin
                    has_nb = 1'b1;
                    if (line_mem[base_up + col] > nb_max)
                        nb_max = line_mem[base_up + col];
                end
                if (!last_row) begin
                    has_nb = 1'b1;
                    if (item.pixel_in > nb_max)
                        nb_max = item.pixel_in;
                end
                if (col > 0) begin
                    has_nb = 1'b1;
                    if (left_val > nb_max)
                        nb_max = left_val;
                end
                if (col + 1 < w) begin
                    has_nb = 1'b1;
                    if (line_mem[base_cur + col + 1] > nb_max)
                        nb_max = line_mem[base_cur + col + 1];
                end

                clip     = has_nb && (centre > nb_max);
                ends_row = (col + 1 >= w);
                res.pixel_out   = clip ? nb_max : centre;
                res.was_clipped = clip;
                res.row_end     = ends_row;
                res.frame_end   = ends_row && last_row;
                clamped_pixel_q = {clamped_pixel_q, res};

                left_val = centre;
                out_col  = col + 1;
                if (ends_row) begin
                    row_pending = 1'b0;
                    out_col     = 0;
                end
            end
        end

        if (is_pixel) begin
            if (in_col < LINE_W)
                line_mem[(in_row & 1) * LINE_W + in_col] = item.pixel_in;
            in_col++;
            // a completed row becomes pending and replaces any older one
            if (in_col >= w) begin
                in_col      = 0;
                row_pending = 1'b1;
                out_row     = in_row;
                out_col     = 0;
                left_val    = '0;
                in_row      = (in_row + 1 >= h) ? 0 : ((in_row + 1) & 16'hFFFF);
            end
        end
    endtask

    // Fields are reported as pixel_out/was_clipped/row_end/frame_end
    task automatic check_result(input t_pixel_out got);
        t_pixel_out want;
        if (clamped_pixel_q.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= REPORT_LIMIT)
                $display("%0t: unexpected result %h/%b/%b/%b",
                         $realtime, got.pixel_out, got.was_clipped, got.row_end,
                         got.frame_end);
        end else begin
            want = clamped_pixel_q.pop_front();
            if (got.pixel_out   !== want.pixel_out   ||
                got.was_clipped !== want.was_clipped ||
                got.row_end     !== want.row_end     ||
                got.frame_end   !== want.frame_end) begin
                o_fail_count++;
                if (o_fail_count <= REPORT_LIMIT)
                    $display("%0t: mismatch expected %h/%b/%b/%b got %h/%b/%b/%b",
                             $realtime, want.pixel_out, want.was_clipped, want.row_end,
                             want.frame_end, got.pixel_out, got.was_clipped, got.row_end,
                             got.frame_end);
            end
        end
    endtask

    // Check the result side first, then predict, then apply register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_shadow();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_result(i_out_data);
            if (i_in_valid && !i_in_stall)
                predict_clamped_pixel(i_in_data);
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH: begin
                        width_reg = i_cfg_wr_data[10:0];
                    end
                    CFG_FRAME_HEIGHT: begin
                        height_reg = i_cfg_wr_data[15:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending = clamped_pixel_q.size();
    end

endmodule

>>> tb/sv/local_peak_clamp_filter_core_tb.sv
// ============================================================================
// local_peak_clamp_filter_core_tb: testbench top for the peak clamp core
// Drives raster pixels and flush ticks with random gaps and output stalls,
// reprograms the frame size between phases, and gives the verdict from the
// failure count and pending results of the checker that sits beside the core.
// ============================================================================

module local_peak_clamp_filter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lpcf_pkg::*;

    localparam int unsigned RANDOM_PIXELS  = 750;
    localparam int unsigned FILL_W         = 20;
    localparam int unsigned LONG_HOLD_CYC  = 300;
    localparam int unsigned DRAIN_CYC      = 8;
    localparam int unsigned END_WAIT_LIMIT = 20000;
    localparam int unsigned RUN_LIMIT_NS   = 12_000_000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    t_pixel_in              in_data;
    logic                   out_valid;
    logic                   out_stall;
    t_pixel_out             out_data;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    int                     fail_count;
    int                     pending;

    // Stimulus shaping shared between the sender and the stall generator
    bit                     tx_quiet;
    bit                     rx_quiet;
    bit                     hold_req;
    bit                     hold_on;
    bit                     hold_done;
    int unsigned            pixels_sent;

    always #6 clk = ~clk;

    local_peak_clamp_filter_core u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wr_data (cfg_wr_data)
    );

    peak_clamp_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wr_data (cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Mostly no gap, some short ones, a few long ones
    function automatic int unsigned idle_cycles(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Small values make ties and peaks common; extremes and full range too
    function automatic logic [15:0] rand_pixel();
        int unsigned r;
        logic [15:0] v;
        r = $urandom_range(0, 99);
        v = 16'($urandom);
        if (r < 30)
            v = 16'($urandom_range(0, 7));
        else if (r < 36)
            v = 16'h0000;
        else if (r < 42)
            v = 16'hFFFF;
        return v;
    endfunction

    // Offer one item and hold it until the transfer; entered and left at negedge
    task automatic push_item(input logic act, input logic [15:0] pix);
        int unsigned gap;
        gap = idle_cycles(tx_quiet);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid         = 1'b1;
        in_data.action   = act;
        in_data.pixel_in = pix;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (act == ACT_PIXEL)
            pixels_sent++;
        @(negedge clk);
    endtask

    task automatic send_pixels(input int unsigned count, input bit noisy);
        for (int unsigned k = 0; k < count; k++) begin
            if (noisy && $urandom_range(0, 9) == 0)
                push_item(ACT_FLUSH, rand_pixel());
            push_item(ACT_PIXEL, rand_pixel());
        end
    endtask

    task automatic send_flushes(input int unsigned count);
        for (int unsigned k = 0; k < count; k++)
            push_item(ACT_FLUSH, rand_pixel());
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Drop valid, wait for every predicted result, then let the pipeline drain
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
    endtask

    // Receiver: random stalls, one long hold-off on request
    initial begin : out_stall_gen
        int unsigned n;
        out_stall = 1'b0;
        forever begin
            if (hold_req && !hold_done) begin
                out_stall = 1'b1;
                hold_on   = 1'b1;
                repeat (LONG_HOLD_CYC) @(negedge clk);
                hold_done = 1'b1;
            end
            n = idle_cycles(rx_quiet);
            if (n != 0) begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("** local_peak_clamp_filter_core: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int unsigned base;
        int unsigned r;
        int unsigned n;
        int unsigned w_eff;
        int unsigned h_eff;
        logic [CFG_DATA_W-1:0] w_reg;
        logic [CFG_DATA_W-1:0] h_reg;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_FRAME_WIDTH;
        cfg_wr_data = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // 1x1 frames: zero registers select width and height of one
        write_reg(CFG_FRAME_WIDTH, 16'd0);
        write_reg(CFG_FRAME_HEIGHT, 16'd0);
        push_item(ACT_FLUSH, 16'hFFFF);      // nothing pending
        push_item(ACT_PIXEL, 16'hFFFF);
        push_item(ACT_FLUSH, 16'h0000);      // single pixel passes unchanged
        push_item(ACT_PIXEL, 16'h0001);
        push_item(ACT_PIXEL, 16'h0000);      // next frame drains the previous one
        push_item(ACT_FLUSH, 16'h5A5A);
        settle();

        // 3x2 frames: peaks inside and on corners, ties, extremes
        write_reg(CFG_FRAME_WIDTH, 16'd3);
        write_reg(CFG_FRAME_HEIGHT, 16'd2);
        push_item(ACT_PIXEL, 16'd5);
        push_item(ACT_PIXEL, 16'd9);
        push_item(ACT_PIXEL, 16'd1);
        push_item(ACT_FLUSH, 16'hFFFF);      // pending row is not the last one
        push_item(ACT_PIXEL, 16'hFFFF);
        push_item(ACT_PIXEL, 16'd2);
        push_item(ACT_PIXEL, 16'd0);
        push_item(ACT_PIXEL, 16'd0);         // next frame while last row pending
        push_item(ACT_PIXEL, 16'd0);
        push_item(ACT_PIXEL, 16'd0);
        push_item(ACT_PIXEL, 16'd7);
        push_item(ACT_PIXEL, 16'd7);
        push_item(ACT_PIXEL, 16'h8000);
        send_flushes(4);
        settle();

        // Two rows at the widest narrow width: fill every column that
        // narrow frames can read in both line stores
        write_reg(CFG_FRAME_WIDTH, 16'(FILL_W));
        write_reg(CFG_FRAME_HEIGHT, 16'd2);
        send_pixels(2 * FILL_W, 1'b0);
        send_flushes(FILL_W);
        settle();

        // First random phase: long receiver hold-off backs up the core
        w_reg = 16'd5;
        h_reg = 16'd8;
        write_reg(CFG_FRAME_WIDTH, w_reg);
        write_reg(CFG_FRAME_HEIGHT, h_reg);
        w_eff    = 32'(w_reg);
        h_eff    = 32'(h_reg);
        hold_req = 1'b1;
        wait (hold_on);
        @(negedge clk);
        send_pixels(40, 1'b0);
        send_flushes(5);

        base = pixels_sent;
        while (pixels_sent - base < RANDOM_PIXELS) begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);

            // New frame size, possibly in the middle of a frame
            if ($urandom_range(0, 99) < 60) begin
                settle();
                r = $urandom_range(0, 99);
                if (r < 55)
                    w_reg = 16'($urandom_range(2, 6));
                else if (r < 70)
                    w_reg = 16'($urandom_range(7, FILL_W));
                else if (r < 80)
                    w_reg = 16'd0;
                else if (r < 88)
                    w_reg = 16'd1;
                else if (r < 94)
                    w_reg = 16'd1024;
                else if (r < 97)
                    w_reg = 16'd2047;
                else
                    w_reg = 16'($urandom_range(1025, 2046));
                r = $urandom_range(0, 99);
                if (r < 60)
                    h_reg = 16'($urandom_range(1, 4));
                else if (r < 75)
                    h_reg = 16'($urandom_range(5, 10));
                else if (r < 85)
                    h_reg = 16'd0;
                else if (r < 93)
                    h_reg = 16'hFFFF;
                else
                    h_reg = 16'($urandom_range(11, 65535));
                // Wide rows never complete here: drain any pending row first
                // as a last row, so nothing is emitted at a wide width
                if (32'(w_reg) > FILL_W) begin
                    write_reg(CFG_FRAME_HEIGHT, 16'd1);
                    send_flushes(w_eff);
                    settle();
                end
                write_reg(CFG_FRAME_WIDTH, w_reg);
                write_reg(CFG_FRAME_HEIGHT, h_reg);
            end
            w_eff = (w_reg == 0) ? 1 : ((w_reg > 1024) ? 1024 : w_reg);
            h_eff = (h_reg == 0) ? 1 : h_reg;

            if ($urandom_range(0, 99) < 75) begin
                // Whole rows and frames, drained by flush ticks
                if (w_eff > 64)
                    send_pixels($urandom_range(1, 40), 1'b1);
                else if (h_eff > 12)
                    send_pixels(w_eff * $urandom_range(2, 5), 1'b1);
                else
                    send_pixels(w_eff * h_eff * $urandom_range(1, 2),
                                1'($urandom_range(0, 1)));
                send_flushes((w_eff <= 64) ? w_eff + $urandom_range(0, 2)
                                           : $urandom_range(0, 3));
            end else begin
                // Broken sequence: pixels and flushes in any order
                n = $urandom_range(1, 30);
                for (int unsigned k = 0; k < n; k++) begin
                    if ($urandom_range(0, 99) < 40)
                        push_item(ACT_FLUSH, rand_pixel());
                    else
                        push_item(ACT_PIXEL, rand_pixel());
                end
            end
        end

        // Drain, then watch for stray results
        in_valid = 1'b0;
        for (int unsigned k = 0; k < END_WAIT_LIMIT && pending != 0; k++)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** local_peak_clamp_filter_core: PASSED **");
        end else begin
            if (pending != 0)
                $display("%0d expected results never arrived", pending);
            $display("** local_peak_clamp_filter_core: FAILED **");
        end
        $finish;
    end

endmodule
